// ===== src/hsv_pkg.sv =====
package hsv_pkg;

  localparam int unsigned HSV_CH_W     = 8;
  localparam int unsigned HSV_HUE_W    = 15;
  localparam int unsigned HSV_FRAC_DEF = 6;
  localparam int unsigned HSV_CH_MAX   = 255;
  localparam int unsigned HSV_DIV_BPS  = 4;

  localparam int unsigned HSV_DEG_60   = 60;
  localparam int unsigned HSV_DEG_120  = 120;
  localparam int unsigned HSV_DEG_240  = 240;
  localparam int unsigned HSV_DEG_360  = 360;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [HSV_CH_W-1:0] mx;
    logic [HSV_CH_W-1:0] delta;
    logic [HSV_CH_W-1:0] mag;
    sector_t             sector;
    logic                neg;
  } prep_t;

  typedef struct packed {
    logic [HSV_CH_W-1:0] mx;
    logic                dz;
    sector_t             sector;
    logic                neg;
  } side_t;

  function automatic int unsigned deg_fx(input int unsigned deg, input int unsigned frac);
    return deg << frac;
  endfunction

endpackage

// ===== src/hsv_ctrl.sv =====
module hsv_ctrl #(
  parameter int unsigned L = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         out_stall,
  output logic         out_valid,
  output logic [L-1:0] en
);

  logic [L-1:0] valid_r;
  logic [L-1:0] valid_nxt;
  logic [L-1:0] rdy;
  logic [L-1:0] vin;

  // a stage takes a new word when it is empty or its successor moves
  always_comb begin
    rdy[L-1] = !valid_r[L-1] || !out_stall;
    for (int k = L - 2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  assign vin       = {valid_r[L-2:0], in_valid};
  assign valid_nxt = (rdy & vin) | (~rdy & valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = valid_r[L-1];
  assign en        = rdy;

endmodule

// ===== src/hsv_prep.sv =====
module hsv_prep (
  input  logic                           clk,
  input  logic                           en,
  input  logic [hsv_pkg::HSV_CH_W-1:0]   red,
  input  logic [hsv_pkg::HSV_CH_W-1:0]   green,
  input  logic [hsv_pkg::HSV_CH_W-1:0]   blue,
  output hsv_pkg::prep_t                 prep
);

  import hsv_pkg::*;

  prep_t               prep_r;
  prep_t               prep_nxt;
  logic [HSV_CH_W-1:0] mx;
  logic [HSV_CH_W-1:0] mn;
  logic [HSV_CH_W-1:0] a;
  logic [HSV_CH_W-1:0] b;
  sector_t             sec;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;

    // ties go to red, then green
    priority if (mx == red) begin
      sec = SEC_RED;
      a   = green;
      b   = blue;
    end else if (mx == green) begin
      sec = SEC_GREEN;
      a   = blue;
      b   = red;
    end else begin
      sec = SEC_BLUE;
      a   = red;
      b   = green;
    end

    prep_nxt.mx     = mx;
    prep_nxt.delta  = mx - mn;
    prep_nxt.sector = sec;
    prep_nxt.neg    = a < b;
    prep_nxt.mag    = (a < b) ? (b - a) : (a - b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
    end
  end

  assign prep = prep_r;

endmodule

// ===== src/hsv_div.sv =====
module hsv_div #(
  parameter int unsigned DW   = 8,
  parameter int unsigned QP   = 8,
  parameter int unsigned NSTG = 2
) (
  input  logic               clk,
  input  logic [NSTG-1:0]    en,
  input  logic [QP+DW-1:0]   num,
  input  logic [DW-1:0]      den,
  output logic [QP-1:0]      quo
);

  localparam int unsigned BPS = QP / NSTG;

  logic [DW-1:0] rem_r [NSTG-1];
  logic [QP-1:0] n_r   [NSTG-1];
  logic [DW-1:0] d_r   [NSTG-1];
  logic [QP-1:0] q_r   [NSTG];

  // restoring division, BPS quotient bits per stage, remainder stays below den
  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    logic [DW-1:0] rin;
    logic [DW-1:0] rem_nxt;
    logic [QP-1:0] nin;
    logic [QP-1:0] qin;
    logic [QP-1:0] q_nxt;
    logic [DW-1:0] din;

    if (i == 0) begin : g_first
      assign rin = num[QP+DW-1:QP];
      assign nin = num[QP-1:0];
      assign din = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[i-1];
      assign nin = n_r[i-1];
      assign din = d_r[i-1];
      assign qin = q_r[i-1];
    end

    always_comb begin
      logic [DW:0] sh;
      int          j;
      rem_nxt = rin;
      q_nxt   = qin;
      for (int k = 0; k < int'(BPS); k++) begin
        j  = int'(QP) - 1 - i * int'(BPS) - k;
        sh = {rem_nxt, nin[j]};
        if (sh >= {1'b0, din}) begin
          sh       = sh - {1'b0, din};
          q_nxt[j] = 1'b1;
        end
        rem_nxt = sh[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        q_r[i] <= q_nxt;
      end
    end

    if (i < NSTG - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[i]) begin
          rem_r[i] <= rem_nxt;
          n_r[i]   <= nin;
          d_r[i]   <= din;
        end
      end
    end
  end

  assign quo = q_r[NSTG-1];

endmodule

// ===== src/rgb_to_hsv_converter_top.sv =====
// channel   ports                                   direction
// input     in_valid in_stall in_red in_green in_blue  pixel in
// output    out_valid out_stall out_hue out_saturation out_brightness  hsv out
//
// one word per cycle sustained while the output is not stalled; the divider depth is set by
// qbits, the bit count of 60 degrees in hue units (3 divider stages at the default
// of 6 fraction bits)
// the hue and saturation dividers are the pipelined restoring units that set the depth
// reset clears only the valid bits; a stalled output freezes only the full stages behind it, empty ones still fill
module rgb_to_hsv_converter_top #(
  parameter int unsigned HUE_FRAC_BITS = hsv_pkg::HSV_FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [hsv_pkg::HSV_CH_W-1:0]   in_red,
  input  logic [hsv_pkg::HSV_CH_W-1:0]   in_green,
  input  logic [hsv_pkg::HSV_CH_W-1:0]   in_blue,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hsv_pkg::HSV_HUE_W-1:0]  out_hue,
  output logic [hsv_pkg::HSV_CH_W-1:0]   out_saturation,
  output logic [hsv_pkg::HSV_CH_W-1:0]   out_brightness
);

  import hsv_pkg::*;

  localparam int unsigned DEG60  = deg_fx(HSV_DEG_60, HUE_FRAC_BITS);
  localparam int unsigned DEG120 = deg_fx(HSV_DEG_120, HUE_FRAC_BITS);
  localparam int unsigned DEG240 = deg_fx(HSV_DEG_240, HUE_FRAC_BITS);
  localparam int unsigned DEG360 = deg_fx(HSV_DEG_360, HUE_FRAC_BITS);
  localparam int unsigned QW     = $clog2(DEG60 + 1);
  localparam int unsigned NSTG   = (QW + HSV_DIV_BPS - 1) / HSV_DIV_BPS;
  localparam int unsigned QPH    = NSTG * HSV_DIV_BPS;
  localparam int unsigned QPS    = NSTG * ((HSV_CH_W + NSTG - 1) / NSTG);
  localparam int unsigned NWH    = QPH + HSV_CH_W;
  localparam int unsigned NWS    = QPS + HSV_CH_W;
  localparam int unsigned L      = NSTG + 2;
  localparam int unsigned HCW    = $clog2(DEG360 + 1);

  logic [L-1:0]          en;
  prep_t                 prep;
  logic [NWH-1:0]        num_h;
  logic [NWS-1:0]        num_s;
  logic [QPH-1:0]        quo_h;
  logic [QPS-1:0]        quo_s;
  side_t                 side_r [NSTG];
  side_t                 side_l;
  logic [HCW-1:0]        q_h;
  logic [HCW-1:0]        off;
  logic [HCW-1:0]        hue_full;
  logic [HSV_HUE_W-1:0]  hue_r;
  logic [HSV_HUE_W-1:0]  hue_nxt;
  logic [HSV_CH_W-1:0]   sat_r;
  logic [HSV_CH_W-1:0]   sat_nxt;
  logic [HSV_CH_W-1:0]   bri_r;

  hsv_ctrl #(
    .L (L)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .en        (en)
  );

  hsv_prep u_prep (
    .clk   (clk),
    .en    (en[0]),
    .red   (in_red),
    .green (in_green),
    .blue  (in_blue),
    .prep  (prep)
  );

  assign num_h = NWH'(prep.mag) * NWH'(DEG60);
  assign num_s = NWS'(prep.delta) * NWS'(HSV_CH_MAX);

  hsv_div #(
    .DW   (HSV_CH_W),
    .QP   (QPH),
    .NSTG (NSTG)
  ) u_div_hue (
    .clk (clk),
    .en  (en[NSTG:1]),
    .num (num_h),
    .den (prep.delta),
    .quo (quo_h)
  );

  hsv_div #(
    .DW   (HSV_CH_W),
    .QP   (QPS),
    .NSTG (NSTG)
  ) u_div_sat (
    .clk (clk),
    .en  (en[NSTG:1]),
    .num (num_s),
    .den (prep.mx),
    .quo (quo_s)
  );

  for (genvar i = 0; i < NSTG; i++) begin : g_side
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[1]) begin
          side_r[0].mx     <= prep.mx;
          side_r[0].dz     <= prep.delta == '0;
          side_r[0].sector <= prep.sector;
          side_r[0].neg    <= prep.neg;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[i+1]) begin
          side_r[i] <= side_r[i-1];
        end
      end
    end
  end

  assign side_l = side_r[NSTG-1];
  assign q_h    = HCW'(quo_h);

  always_comb begin
    unique case (side_l.sector)
      SEC_RED:   off = (side_l.neg && q_h != '0) ? HCW'(DEG360) : '0;
      SEC_GREEN: off = HCW'(DEG120);
      SEC_BLUE:  off = HCW'(DEG240);
      default:   off = '0;
    endcase
    hue_full = side_l.neg ? (off - q_h) : (off + q_h);
    hue_nxt  = side_l.dz ? '0 : HSV_HUE_W'(hue_full);
    sat_nxt  = (side_l.mx == '0) ? '0 : HSV_CH_W'(quo_s);
  end

  always_ff @(posedge clk) begin
    if (en[L-1]) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      bri_r <= side_l.mx;
    end
  end

  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bri_r;

endmodule

// ===== src/hsv_checker.sv =====
module hsv_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [hsv_pkg::HSV_HUE_W-1:0]  out_hue,
  input logic [hsv_pkg::HSV_CH_W-1:0]   out_saturation,
  input logic [hsv_pkg::HSV_CH_W-1:0]   out_brightness
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      $stable(out_hue) && $stable(out_saturation) && $stable(out_brightness))
    else $error("stalled output word changed");

  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is free");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_brightness == '0 |-> out_saturation == '0 && out_hue == '0)
    else $error("black pixel with nonzero hue or saturation");

  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturation == '0 |-> out_hue == '0)
    else $error("grey pixel with nonzero hue");

endmodule

bind rgb_to_hsv_converter_top hsv_checker u_hsv_checker (.*);
